// File: rtl/dcf_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// density/current Fourier component block. No dependencies.
package dcf_pkg;

   localparam int MAX_PARTICLES_DEF = 16777216;
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int ATAN_LEN          = 24;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [31:0]        INV_TWO_PI = 32'd683565276;
   localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;

   // configuration register indexes
   localparam logic [1:0] CSR_WAVE_X = 2'd0;
   localparam logic [1:0] CSR_WAVE_Y = 2'd1;
   localparam logic [1:0] CSR_WAVE_Z = 2'd2;

   // one classified particle handed from front to back
   typedef struct packed {
      logic [31:0]        turns;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic               last;
   } item_type;

   // arctangent of 2^-i in turns, Q0.32
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/dcf_queue.sv
// Short register queue between front and back of the block.
// Depends on dcf_pkg (item_type, QUEUE_DEPTH).
module dcf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dcf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dcf_pkg::item_type pop_item
);

   localparam int PW = (dcf_pkg::QUEUE_DEPTH > 1) ? $clog2(dcf_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(dcf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(dcf_pkg::QUEUE_DEPTH);

   dcf_pkg::item_type slot_ff [dcf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == DEPTH_C);
   assign empty    = (cnt_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(dcf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(dcf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/dcf_front.sv
// Front end: accepts particles, holds the wave vector registers and
// turns position into phase in turns. Depends on dcf_pkg.
module dcf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] pos_z,
   input  logic signed [23:0] vel_x,
   input  logic signed [23:0] vel_y,
   input  logic signed [23:0] vel_z,
   input  logic               last_particle,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic               push,
   output dcf_pkg::item_type  push_item,
   input  logic               queue_full
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   logic signed [31:0] wave_x_ff, wave_y_ff, wave_z_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [23:0] vx_ff, vy_ff, vz_ff;
   logic               last_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [47:0] prod_sh;
   logic signed [49:0] phase_ff, phase_in;
   logic [55:0]        ph56;
   logic [59:0]        mlo_ff, mlo_in, mhi_full;
   logic [27:0]        mhi_ff, mhi_in;
   logic [55:0]        turn_sum;
   logic [31:0]        turns_ff, turns_in;
   logic               accept;

   assign accept = start && (state_ff == F_IDLE);
   assign busy   = (state_ff != F_IDLE);
   assign push   = (state_ff == F_PUSH) && !queue_full;

   assign push_item = '{turns: turns_ff, vel_x: vx_ff, vel_y: vy_ff, vel_z: vz_ff,
                        last: last_ff};

   // one shared 32x32 multiplier walks the three axes
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            mul_a = px_ff;
            mul_b = wave_x_ff;
         end
         2'd1: begin
            mul_a = py_ff;
            mul_b = wave_y_ff;
         end
         default: begin
            mul_a = pz_ff;
            mul_b = wave_z_ff;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_sh  = prod_ff[63:16];
   assign ph56     = {{6{phase_ff[49]}}, phase_ff};
   assign mlo_in   = 60'(ph56[27:0]) * 60'(dcf_pkg::INV_TWO_PI);
   assign mhi_full = 60'(ph56[55:28]) * 60'(dcf_pkg::INV_TWO_PI);
   assign mhi_in   = mhi_full[27:0];
   assign turn_sum = mlo_ff[55:0] + {mhi_ff, 28'd0};
   assign turns_in = turn_sum[55:24];

   always_comb begin
      phase_in = phase_ff;
      if (step_ff == 3'd1) begin
         phase_in = {{2{prod_sh[47]}}, prod_sh};
      end else if (step_ff == 3'd2 || step_ff == 3'd3) begin
         phase_in = phase_ff + {{2{prod_sh[47]}}, prod_sh};
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in = F_CALC;
               step_in  = '0;
            end
         end
         F_CALC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd6) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         step_ff   <= '0;
         wave_x_ff <= '0;
         wave_y_ff <= '0;
         wave_z_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_we) begin
            case (csr_index)
               dcf_pkg::CSR_WAVE_X: wave_x_ff <= csr_wdata;
               dcf_pkg::CSR_WAVE_Y: wave_y_ff <= csr_wdata;
               dcf_pkg::CSR_WAVE_Z: wave_z_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff   <= pos_x;
         py_ff   <= pos_y;
         pz_ff   <= pos_z;
         vx_ff   <= vel_x;
         vy_ff   <= vel_y;
         vz_ff   <= vel_z;
         last_ff <= last_particle;
      end
      if (state_ff == F_CALC) begin
         prod_ff  <= prod_in;
         phase_ff <= phase_in;
         if (step_ff == 3'd4) begin
            mlo_ff <= mlo_in;
         end
         if (step_ff == 3'd5) begin
            mhi_ff <= mhi_in;
         end
         if (step_ff == 3'd6) begin
            turns_ff <= turns_in;
         end
      end
   end

endmodule

// File: rtl/dcf_back.sv
// Back end: CORDIC sine/cosine, saturating accumulation, square root and
// per-sum division on the last particle. Depends on dcf_pkg.
module dcf_back #(
   parameter int MAX_PARTICLES = dcf_pkg::MAX_PARTICLES_DEF,
   parameter int CORDIC_STEPS  = dcf_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   output logic              pop,
   input  dcf_pkg::item_type item,
   output logic              rsp_valid,
   output logic [7:0][47:0]  rsp_sum
);

   localparam int CW  = $clog2(MAX_PARTICLES + 1);
   localparam int RW  = (CW + 33) / 2;
   localparam int RBW = $clog2(RW);
   localparam int NW  = 62;
   localparam int DCW = $clog2(NW + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PARTICLES);

   typedef enum logic [7:0] {
      B_IDLE = 8'b0000_0001,
      B_ROT  = 8'b0000_0010,
      B_TRIG = 8'b0000_0100,
      B_ACC  = 8'b0000_1000,
      B_ROOT = 8'b0001_0000,
      B_DSET = 8'b0010_0000,
      B_DIV  = 8'b0100_0000,
      B_DONE = 8'b1000_0000
   } back_state_type;

   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [19:0] r;
      t = {v[33], v} + 35'sd16384;
      r = t[34:15];
      if (r > 20'sd32767) begin
         return 16'sd32767;
      end else if (r < -20'sd32768) begin
         return -16'sd32768;
      end
      return r[15:0];
   endfunction

   back_state_type state_ff, state_in;

   dcf_pkg::item_type  item_ff;
   logic [1:0]         q_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [4:0]         i_ff;
   logic signed [15:0] c_ff, s_ff;
   logic [3:0]         k_ff;
   logic signed [27:0] term_ff;
   logic signed [47:0] sum_ff [8];
   logic [CW-1:0]      cnt_ff;
   logic [RW-1:0]      root_ff;
   logic [RBW-1:0]     rb_ff;
   logic [NW-1:0]      num_ff;
   logic [RW:0]        rem_ff, div_ff;
   logic [DCW-1:0]     dcnt_ff;
   logic               neg_ff;
   logic [47:0]        out_ff [8];
   logic               valid_ff;

   // quadrant split
   logic [31:0]        turn_bias, resid;
   logic [1:0]         quad;
   // CORDIC step
   logic signed [33:0] xs, ys;
   logic signed [33:0] atan_v;
   // rotation by quadrant
   logic signed [33:0] cr, sr;
   // accumulate
   logic signed [15:0] trig;
   logic signed [23:0] vel;
   logic signed [39:0] tv;
   logic signed [39:0] tv_rnd;
   logic signed [27:0] term_in;
   logic [2:0]         idx;
   logic signed [48:0] acc_sum;
   logic signed [47:0] acc_sat;
   // square root
   logic [RW-1:0]      trial;
   logic [2*RW-1:0]    trial_sq;
   logic [CW+31:0]     rad;
   logic [RW-1:0]      root_v;
   // division
   logic [47:0]        mag;
   logic [RW+1:0]      rem_sh;
   logic               ge;
   logic [NW-1:0]      num_in;
   logic [47:0]        quo;

   assign pop       = (state_ff == B_IDLE) && !queue_empty;
   assign rsp_valid = valid_ff;

   for (genvar g = 0; g < 8; g++) begin : g_out
      assign rsp_sum[g] = out_ff[g];
   end

   assign turn_bias = item.turns + 32'h2000_0000;
   assign quad      = turn_bias[31:30];
   assign resid     = item.turns - {quad, 30'd0};

   assign xs     = x_ff >>> i_ff;
   assign ys     = y_ff >>> i_ff;
   assign atan_v = $signed({2'b00, dcf_pkg::atan_turns(i_ff)});

   always_comb begin
      unique case (q_ff)
         2'd0: begin
            cr = x_ff;
            sr = y_ff;
         end
         2'd1: begin
            cr = -y_ff;
            sr = x_ff;
         end
         2'd2: begin
            cr = -x_ff;
            sr = -y_ff;
         end
         2'd3: begin
            cr = y_ff;
            sr = -x_ff;
         end
      endcase
   end

   always_comb begin
      trig = k_ff[0] ? s_ff : c_ff;
      unique case (k_ff[2:1])
         2'd1:    vel = item_ff.vel_x;
         2'd2:    vel = item_ff.vel_y;
         default: vel = item_ff.vel_z;
      endcase
   end

   assign tv      = trig * vel;
   assign tv_rnd  = (tv + 40'sd2048) >>> 12;
   assign term_in = (k_ff[3:1] == 3'd0) ? 28'(trig) : tv_rnd[27:0];

   // one read index for the sums: in accumulate the registered term belongs to k - 1, so the index trails k by one
   assign idx     = (state_ff == B_ACC) ? 3'(k_ff - 1'b1) : k_ff[2:0];
   assign acc_sum = {sum_ff[idx][47], sum_ff[idx]} + 49'(term_ff);
   assign acc_sat = (acc_sum[48] != acc_sum[47])
                  ? {acc_sum[48], {47{~acc_sum[48]}}} : acc_sum[47:0];

   assign trial    = root_ff | (RW'(1) << rb_ff);
   assign trial_sq = (2*RW)'(trial) * (2*RW)'(trial);
   assign rad      = {cnt_ff, 32'd0};
   assign root_v   = (root_ff == '0) ? RW'(1) : root_ff;

   assign mag    = sum_ff[idx][47] ? 48'(-sum_ff[idx]) : sum_ff[idx];
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};
   assign num_in = {num_ff[NW-2:0], ge};
   assign quo    = neg_ff ? 48'(-num_in[47:0]) : num_in[47:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!queue_empty) state_in = B_ROT;
         B_ROT:  if (i_ff == 5'(CORDIC_STEPS - 1)) state_in = B_TRIG;
         B_TRIG: state_in = B_ACC;
         B_ACC: begin
            if (k_ff == 4'd8) begin
               state_in = item_ff.last ? B_ROOT : B_IDLE;
            end
         end
         B_ROOT: if (rb_ff == '0) state_in = B_DSET;
         B_DSET: state_in = B_DIV;
         B_DIV: begin
            if (dcnt_ff == DCW'(1)) begin
               state_in = (k_ff == 4'd7) ? B_DONE : B_DSET;
            end
         end
         B_DONE: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         for (int n = 0; n < 8; n++) begin
            sum_ff[n] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == B_DONE);
         if (state_ff == B_ACC) begin
            if (k_ff != 4'd0) begin
               sum_ff[idx] <= acc_sat;
            end
            if (k_ff == 4'd8 && cnt_ff < MAX_C) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         // result leaves: clear for the next set
         if (state_ff == B_DONE) begin
            cnt_ff <= '0;
            for (int n = 0; n < 8; n++) begin
               sum_ff[n] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            item_ff <= item;
            q_ff    <= quad;
            z_ff    <= 34'($signed(resid));
            x_ff    <= dcf_pkg::CORDIC_X0;
            y_ff    <= '0;
            i_ff    <= '0;
         end
         B_ROT: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_v;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_v;
            end
            i_ff <= i_ff + 1'b1;
         end
         B_TRIG: begin
            c_ff <= to_q15(cr);
            s_ff <= to_q15(sr);
            k_ff <= '0;
         end
         B_ACC: begin
            term_ff <= term_in;
            if (k_ff == 4'd8) begin
               k_ff    <= '0;
               root_ff <= '0;
               rb_ff   <= RBW'(RW - 1);
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
         B_ROOT: begin
            if ((2*RW + 1)'(trial_sq) <= (2*RW + 1)'(rad)) begin
               root_ff <= trial;
            end
            rb_ff <= rb_ff - 1'b1;
         end
         B_DSET: begin
            neg_ff  <= sum_ff[idx][47];
            num_ff  <= {mag, 14'd0} + NW'(root_v);
            div_ff  <= {root_v, 1'b0};
            rem_ff  <= '0;
            dcnt_ff <= DCW'(NW);
         end
         B_DIV: begin
            rem_ff  <= ge ? (RW+1)'(rem_sh - {1'b0, div_ff}) : rem_sh[RW:0];
            num_ff  <= num_in;
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == DCW'(1)) begin
               out_ff[k_ff[2:0]] <= quo;
               k_ff              <= k_ff + 1'b1;
            end
         end
         B_DONE: begin
            k_ff <= '0;
         end
      endcase
   end

endmodule

// File: rtl/density_current_fourier_component_top.sv
// In the front a particle's phase is summed over the three axes and scaled
// into turns; the back then runs the CORDIC rotation, the quadrant fix and
// the 8 sums, one sum per cycle. The back takes a new particle only after
// the last sum of the one before; meanwhile the front may fill the queue.
// The last particle adds a bitwise square root and a bit-serial division of each sum before
// the one-cycle rsp_valid strobe; reset clears sums, count and wave vector.
module density_current_fourier_component_top #(
   parameter int MAX_PARTICLES = dcf_pkg::MAX_PARTICLES_DEF,
   parameter int CORDIC_STEPS  = dcf_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // particle transactions
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [23:0] req_vel_x,
   input  logic signed [23:0] req_vel_y,
   input  logic signed [23:0] req_vel_z,
   input  logic               req_last_particle,
   // result transactions, one cycle each
   output logic               rsp_valid,
   output logic signed [47:0] rsp_rho_cos,
   output logic signed [47:0] rsp_rho_sin,
   output logic signed [47:0] rsp_cur_x_cos,
   output logic signed [47:0] rsp_cur_x_sin,
   output logic signed [47:0] rsp_cur_y_cos,
   output logic signed [47:0] rsp_cur_y_sin,
   output logic signed [47:0] rsp_cur_z_cos,
   output logic signed [47:0] rsp_cur_z_sin,
   // wave vector registers
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   dcf_pkg::item_type push_item, pop_item;
   logic              push, pop, queue_full, queue_empty;
   logic [7:0][47:0]  sums;

   // front: take the transaction, form the phase, hand turns to the queue
   dcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .pos_x         (req_pos_x),
      .pos_y         (req_pos_y),
      .pos_z         (req_pos_z),
      .vel_x         (req_vel_x),
      .vel_y         (req_vel_y),
      .vel_z         (req_vel_z),
      .last_particle (req_last_particle),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .push          (push),
      .push_item     (push_item),
      .queue_full    (queue_full)
   );

   // decouple: hold up to two classified particles while the back is busy
   dcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   // back: sin/cos, accumulate, and scale on the last particle
   dcf_back #(
      .MAX_PARTICLES (MAX_PARTICLES),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop         (pop),
      .item        (pop_item),
      .rsp_valid   (rsp_valid),
      .rsp_sum     (sums)
   );

   // sums come out in result field order
   assign rsp_rho_cos   = sums[0];
   assign rsp_rho_sin   = sums[1];
   assign rsp_cur_x_cos = sums[2];
   assign rsp_cur_x_sin = sums[3];
   assign rsp_cur_y_cos = sums[4];
   assign rsp_cur_y_sin = sums[5];
   assign rsp_cur_z_cos = sums[6];
   assign rsp_cur_z_sin = sums[7];

endmodule
